### sv/rgb_to_hsv_converter_macros.svh
// assertion macros for the rgb to hsv converter
`ifndef RGB_TO_HSV_CONVERTER_MACROS_SVH
`define RGB_TO_HSV_CONVERTER_MACROS_SVH

// property that holds on every edge outside reset
`define R2H_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked at the next edge
`define R2H_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/r2h_pkg.sv
package r2h_pkg;
	// hue sector offset in units of d (K)
	typedef enum logic [1:0] {
		SEC_RED_UP = 2'd0,
		SEC_RED_DN = 2'd1,
		SEC_GREEN  = 2'd2,
		SEC_BLUE   = 2'd3
	} sector_t;

	// classified item handed from front to back, n is two's complement
	typedef struct packed {
		logic [7:0] vmax;
		logic [7:0] d;
		logic [8:0] n;
		sector_t    sector;
		logic       gray;
		logic       last;
	} cls_t;

	localparam int unsigned DivSteps = 8;
endpackage

### sv/r2h_front.sv
// classifies a pixel: max, range, numerator and hue sector
module r2h_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid,
	output logic              ready,
	input  logic [7:0]        red,
	input  logic [7:0]        green,
	input  logic [7:0]        blue,
	input  logic              last_pixel,
	output logic              cls_valid,
	input  logic              cls_ready,
	output r2h_pkg::cls_t     cls
);
	r2h_pkg::cls_t c;
	logic [7:0] vmax, vmin;

	// max, min and sector with red then green priority
	always_comb begin
		vmax = (red > green) ? red : green;
		vmax = (vmax > blue) ? vmax : blue;
		vmin = (red < green) ? red : green;
		vmin = (vmin < blue) ? vmin : blue;
		c.vmax = vmax;
		c.d = vmax - vmin;
		c.gray = (vmax == vmin);
		c.last = last_pixel;
		// signed n of the sector, negative values wrap in nine bits
		if (vmax == red && green >= blue) begin
			c.sector = r2h_pkg::SEC_RED_UP;
			c.n = {1'b0, green} - {1'b0, blue};
		end else if (vmax == red) begin
			c.sector = r2h_pkg::SEC_RED_DN;
			c.n = {1'b0, green} - {1'b0, blue};
		end else if (vmax == green) begin
			c.sector = r2h_pkg::SEC_GREEN;
			c.n = {1'b0, blue} - {1'b0, red};
		end else begin
			c.sector = r2h_pkg::SEC_BLUE;
			c.n = {1'b0, red} - {1'b0, green};
		end
	end

	// output register
	assign ready = !cls_valid || cls_ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_valid <= 1'b0;
		end else if (ready) begin
			cls_valid <= valid;
		end
	end
	always_ff @(posedge clk) begin
		if (ready && valid) begin
			cls <= c;
		end
	end
endmodule

### sv/r2h_fifo.sv
// short queue between front and back
module r2h_fifo #(
	parameter int unsigned DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  r2h_pkg::cls_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output r2h_pkg::cls_t out_data
);
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	r2h_pkg::cls_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != (AW+1)'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_data = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (pop) rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_data;
	end
endmodule

### sv/r2h_back.sv
// pipelined restoring dividers for saturation and hue
module r2h_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  r2h_pkg::cls_t in_data,
	output logic          valid,
	input  logic          ready,
	output logic [7:0]    hue_out,
	output logic [7:0]    sat_out,
	output logic [7:0]    val_out,
	output logic          last_out
);
	localparam int unsigned NS = r2h_pkg::DivSteps;
	logic        adv;
	logic [10:0] n_ext;
	logic [10:0] num;
	logic        v_q;
	logic [16:0] hn_q;
	logic [15:0] sn_q;
	logic [8:0]  hd_q;
	logic [7:0]  sd_q, vm_q;
	logic        g_q, l_q;
	// per stage: remainders, quotients and carried fields
	logic        vv_s [NS+1];
	logic [16:0] hrem_s [NS+1];
	logic [15:0] srem_s [NS+1];
	logic [7:0]  hq_s [NS+1];
	logic [7:0]  sq_s [NS+1];
	logic [8:0]  hdd_s [NS+1];
	logic [7:0]  sdd_s [NS+1];
	logic [7:0]  vmm_s [NS+1];
	logic        gg_s [NS+1];
	logic        ll_s [NS+1];

	assign adv = !valid || ready;
	assign in_ready = adv;

	// hue numerator K*d + n, never negative and below 2048
	assign n_ext = {{2{in_data.n[8]}}, in_data.n};
	always_comb begin
		case (in_data.sector)
			r2h_pkg::SEC_RED_UP: num = n_ext;
			r2h_pkg::SEC_RED_DN: num = ({3'd0, in_data.d} * 11'd6) + n_ext;
			r2h_pkg::SEC_GREEN:  num = ({3'd0, in_data.d} << 1) + n_ext;
			default:             num = ({3'd0, in_data.d} << 2) + n_ext;
		endcase
	end

	// register after the multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= 1'b0;
		else if (adv) v_q <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			hn_q <= {6'd0, num} * 17'd85;
			sn_q <= {8'd0, in_data.d} * 16'd255;
			hd_q <= {in_data.d, 1'b0};
			sd_q <= in_data.vmax;
			vm_q <= in_data.vmax;
			g_q <= in_data.gray;
			l_q <= in_data.last;
		end
	end

	assign hrem_s[0] = hn_q;
	assign srem_s[0] = sn_q;
	assign hq_s[0] = '0;
	assign sq_s[0] = '0;
	assign vv_s[0] = v_q;
	assign hdd_s[0] = hd_q;
	assign sdd_s[0] = sd_q;
	assign vmm_s[0] = vm_q;
	assign gg_s[0] = g_q;
	assign ll_s[0] = l_q;

	// long division, one quotient bit of each result per stage
	for (genvar k = 0; k < NS; k++) begin : g_div
		localparam int unsigned SH = NS - 1 - k;
		logic [16:0] hr;
		logic [15:0] sr;
		logic [7:0]  hq, sq;
		logic        v_r;
		logic [16:0] hr_r;
		logic [15:0] sr_r;
		logic [7:0]  hq_r, sq_r;
		logic [8:0]  hd_r;
		logic [7:0]  sd_r, vm_r;
		logic        g_r, l_r;
		// msb first compare and subtract
		always_comb begin
			hr = hrem_s[k];
			hq = hq_s[k];
			if (hr >= ({8'd0, hdd_s[k]} << SH)) begin
				hr = hr - ({8'd0, hdd_s[k]} << SH);
				hq[SH] = 1'b1;
			end
			sr = srem_s[k];
			sq = sq_s[k];
			if (sr >= ({8'd0, sdd_s[k]} << SH)) begin
				sr = sr - ({8'd0, sdd_s[k]} << SH);
				sq[SH] = 1'b1;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_r <= 1'b0;
			else if (adv) v_r <= vv_s[k];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				hr_r <= hr; hq_r <= hq; sr_r <= sr; sq_r <= sq;
				hd_r <= hdd_s[k]; sd_r <= sdd_s[k]; vm_r <= vmm_s[k];
				g_r <= gg_s[k]; l_r <= ll_s[k];
			end
		end
		assign vv_s[k+1] = v_r;
		assign hrem_s[k+1] = hr_r;
		assign hq_s[k+1] = hq_r;
		assign srem_s[k+1] = sr_r;
		assign sq_s[k+1] = sq_r;
		assign hdd_s[k+1] = hd_r;
		assign sdd_s[k+1] = sd_r;
		assign vmm_s[k+1] = vm_r;
		assign gg_s[k+1] = g_r;
		assign ll_s[k+1] = l_r;
	end

	assign valid = vv_s[NS];
	assign hue_out = gg_s[NS] ? 8'd0 : hq_s[NS];
	assign sat_out = gg_s[NS] ? 8'd0 : sq_s[NS];
	assign val_out = vmm_s[NS];
	assign last_out = ll_s[NS];

	// remainders of the last stage are not needed
	logic unused;
	assign unused = ^{hrem_s[NS], srem_s[NS], hdd_s[NS], sdd_s[NS]};
endmodule

### sv/rgb_to_hsv_converter.sv
// RGB to HSV converter, 8 bits per channel. A front stage registers max, range
// and hue sector; a two-entry queue decouples it from a back pipeline of one
// multiply stage and eight restoring-divide stages. One pixel is accepted per
// clock when the output is taken every clock; a stalled output holds the whole back
// pipeline. Black and gray pixels give hue and saturation 0. last_out follows
// its pixel.
module rgb_to_hsv_converter #(
	parameter int unsigned QDEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid,
	output logic       ready,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	input  logic       last_pixel,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] hue_out,
	output logic [7:0] sat_out,
	output logic [7:0] val_out,
	output logic       last_out
);
`include "rgb_to_hsv_converter_macros.svh"
	r2h_pkg::cls_t f_cls, q_cls;
	logic f_v, f_r, q_v, q_r;

	r2h_front u_front (
		.clk, .arst_n, .valid, .ready, .red, .green, .blue, .last_pixel,
		.cls_valid(f_v), .cls_ready(f_r), .cls(f_cls)
	);
	r2h_fifo #(.DEPTH(QDEPTH)) u_fifo (
		.clk, .arst_n, .in_valid(f_v), .in_ready(f_r), .in_data(f_cls),
		.out_valid(q_v), .out_ready(q_r), .out_data(q_cls)
	);
	r2h_back u_back (
		.clk, .arst_n, .in_valid(q_v), .in_ready(q_r), .in_data(q_cls),
		.valid(out_valid), .ready(out_ready), .hue_out, .sat_out, .val_out,
		.last_out
	);

	// assertions
	`R2H_ASSERT(a_hue_range, !out_valid || hue_out != 8'd255, "hue out of range")
	`R2H_ASSERT(a_sat_black, !out_valid || val_out != '0 || sat_out == '0, "black has sat")
	`R2H_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid, "result dropped")
endmodule

### dv/rgb_to_hsv_checker.sv
module rgb_to_hsv_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid,
	input  logic       ready,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	input  logic       last_pixel,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] hue_out,
	input  logic [7:0] sat_out,
	input  logic [7:0] val_out,
	input  logic       last_out,
	output int         fail_count,
	output int         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] hue;
		logic [7:0] sat;
		logic [7:0] val;
		logic       last;
	} hsv_t;

	hsv_t hsv_queue[$];

	// integer hsv of one pixel
	function automatic hsv_t pixel_to_hsv(logic [7:0] r, logic [7:0] g, logic [7:0] b,
		logic lst);
		hsv_t res;
		int vmax;
		int vmin;
		int d;
		int num;
		vmax = r;
		if (g > vmax) vmax = g;
		if (b > vmax) vmax = b;
		vmin = r;
		if (g < vmin) vmin = g;
		if (b < vmin) vmin = b;
		res.hue = '0;
		res.sat = '0;
		res.val = vmax[7:0];
		res.last = lst;
		if (vmax != 0 && vmax != vmin) begin
			d = vmax - vmin;
			res.sat = 8'((255 * d) / vmax);
			if (vmax == r && g >= b) num = int'(g) - int'(b);
			else if (vmax == r) num = 6 * d + int'(g) - int'(b);
			else if (vmax == g) num = 2 * d + int'(b) - int'(r);
			else num = 4 * d + int'(r) - int'(g);
			res.hue = 8'((85 * num) / (2 * d));
		end
		return res;
	endfunction

	// predict on input, compare on output
	always @(posedge clk or negedge arst_n) begin
		hsv_t want;
		if (!arst_n) begin
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (valid && ready)
				hsv_queue.push_back(pixel_to_hsv(red, green, blue, last_pixel));
			if (out_valid && out_ready) begin
				if (hsv_queue.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected item hue %0d sat %0d val %0d last %0d",
							hue_out, sat_out, val_out, last_out);
				end else begin
					want = hsv_queue.pop_front();
					if (want != {hue_out, sat_out, val_out, last_out}) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("mismatch exp h%0d s%0d v%0d l%0d got h%0d s%0d v%0d l%0d",
								want.hue, want.sat, want.val, want.last,
								hue_out, sat_out, val_out, last_out);
					end
				end
			end
			pending <= hsv_queue.size();
		end
	end
endmodule

### dv/rgb_to_hsv_converter_test.sv
module rgb_to_hsv_converter_test;
	timeunit 1ns;
	timeprecision 1ps;

	logic       clk;
	logic       arst_n;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       last_pixel;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] hue_out;
	logic [7:0] sat_out;
	logic [7:0] val_out;
	logic       last_out;
	int         fail_count;
	int         pending;
	int         idle_cycles = 0;
	logic [7:0] dir_px[25][3];

	rgb_to_hsv_converter i_dut (.*);

	rgb_to_hsv_checker i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog on cycles without any accepted item
	always @(posedge clk) begin
		if ((valid && ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver stalls
	initial begin
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic lst,
		int gap);
		if (gap > 0) begin
			valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		valid <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		last_pixel <= lst;
		do @(posedge clk); while (!ready);
	endtask

	function automatic int draw_gap();
		return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
	endfunction

	initial begin
		int k;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		valid = 1'b0;
		red = '0;
		green = '0;
		blue = '0;
		last_pixel = 1'b0;
		arst_n = 1'b0;
		// black, white, gray, pure and tied maxima, each sector
		dir_px = '{
			'{0, 0, 0}, '{255, 255, 255}, '{128, 128, 128}, '{255, 0, 0},
			'{0, 255, 0}, '{0, 0, 255}, '{255, 255, 0}, '{0, 255, 255},
			'{255, 0, 255}, '{255, 254, 0}, '{255, 0, 1}, '{1, 255, 0},
			'{0, 1, 255}, '{1, 0, 0}, '{0, 1, 0}, '{0, 0, 1},
			'{255, 255, 254}, '{254, 255, 255}, '{255, 254, 255}, '{200, 100, 50},
			'{50, 200, 100}, '{100, 50, 200}, '{170, 85, 0}, '{1, 2, 3},
			'{255, 1, 254}};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (k = 0; k < 25; k++)
			send_pixel(dir_px[k][0], dir_px[k][1], dir_px[k][2], k[0], draw_gap());
		// drain once with the sender held off
		valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		for (k = 0; k < 1550; k++) begin
			r = 8'($urandom);
			g = 8'($urandom);
			b = 8'($urandom);
			case ($urandom_range(0, 7))
				0: g = r;
				1: b = r;
				2: b = g;
				3: begin g = r; b = r; end
				default: ;
			endcase
			send_pixel(r, g, b, 1'($urandom_range(0, 1)),
				(k >= 600 && k < 800) ? 0 : draw_gap());
		end
		valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (fail_count == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end
endmodule
